// File: rtl/wavhp_pkg.sv
package wavhp_pkg;

  localparam int OFFSET_BITS_DEF = 32;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam int MIN_FILE    = 44;
  localparam int MIN_FMT     = 16;
  localparam int CHUNK_START = 12;
  localparam int RIFF_LAST   = 3;
  localparam int WAVE_LAST   = 11;
  localparam int HDR_LAST    = 7;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_SHORT        = 4'd1,
    ST_NO_RIFF      = 4'd2,
    ST_NO_WAVE      = 4'd3,
    ST_FMT_SMALL    = 4'd4,
    ST_NO_DATA      = 4'd5,
    ST_NOT_PCM      = 4'd6,
    ST_NOT_16BIT    = 4'd7,
    ST_BAD_CHANNELS = 4'd8,
    ST_TOO_LONG     = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] data_start;
    logic [30:0] sample_total;
  } res_t;

endpackage

// File: rtl/wav_header_chunk_parser_unit.sv
// channel | dir | ports                                     | moves
// in      | in  | in_valid in_stall in_byte_value in_is_last | one file byte per word
// out     | out | out_valid out_stall out_status            | one summary word per file,
//         |     | out_channel_count out_sample_rate         | after the marked last byte
//         |     | out_data_start out_sample_total           |
//
// one word a cycle unless a last byte waits on a stalled summary; a word goes
// input register -> chunk walker -> result register
// the walker updates its counters and fields once per byte
// rst_n is synchronous; in_stall is high while reset is low
// a stalled summary holds the last byte in the input register; other
// bytes keep flowing past a waiting summary
module wav_header_chunk_parser_unit import wavhp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_data_start,
  output logic [30:0] out_sample_total
);

  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       adv;
  logic       take;
  logic       out_v_r, out_v_nxt;
  res_t       res;
  res_t       res_r;

  assign adv      = s1_v_r && (!s1_last_r || !out_v_r || !out_stall);
  assign in_stall = !rst_n || (s1_v_r && !adv);
  assign take     = in_valid && !in_stall;
  assign s1_v_nxt = take || (s1_v_r && !adv);

  always_comb begin
    if (adv && s1_last_r) begin
      out_v_nxt = 1'b1;
    end else begin
      out_v_nxt = out_v_r && out_stall;
    end
  end

  wavhp_walk #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .byte_in (s1_byte_r),
    .last_in (s1_last_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_is_last;
    end
    if (adv && s1_last_r) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_v_r;
  assign out_status        = res_r.status;
  assign out_channel_count = res_r.channel_count;
  assign out_sample_rate   = res_r.sample_rate;
  assign out_data_start    = res_r.data_start;
  assign out_sample_total  = res_r.sample_total;

endmodule

// File: rtl/wavhp_walk.sv
module wavhp_walk import wavhp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output res_t       res
);

  localparam int CE_W = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic                   over_r, over_nxt;
  logic [63:0]            shift_r, shift_nxt;
  logic                   riff_r, riff_nxt;
  logic                   wave_r, wave_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [CE_W-1:0]        chunk_end_r, chunk_end_nxt;
  logic [CE_W-1:0]        body_start_r, body_start_nxt;
  logic [31:0]            chunk_len_r, chunk_len_nxt;
  logic [15:0]            pend_fmt_r, pend_fmt_nxt;
  logic [15:0]            pend_ch_r, pend_ch_nxt;
  logic [31:0]            pend_rate_r, pend_rate_nxt;
  logic [15:0]            pend_bits_r, pend_bits_nxt;
  logic [15:0]            fmt_code_r, fmt_code_nxt;
  logic [15:0]            ch_num_r, ch_num_nxt;
  logic [31:0]            rate_r, rate_nxt;
  logic [15:0]            bits_r, bits_nxt;
  logic [31:0]            data_begin_r, data_begin_nxt;
  logic [31:0]            data_bytes_r, data_bytes_nxt;
  logic                   fmt_err_r, fmt_err_nxt;
  logic                   stopped_r, stopped_nxt;

  logic [CE_W-1:0] pos_w;
  logic [CE_W-1:0] body_off;
  logic [31:0]     hdr_id;
  logic [31:0]     hdr_len;
  logic            fin;
  kind_t           fin_kind;
  logic [31:0]     fin_len;
  logic [31:0]     fin_begin;

  assign pos_w     = CE_W'(pos_r);
  assign body_off  = pos_w - body_start_r;
  assign shift_nxt = over_r ? shift_r : {byte_in, shift_r[63:8]};
  assign hdr_id    = shift_nxt[31:0];
  assign hdr_len   = shift_nxt[63:32];

  always_comb begin
    pos_nxt        = pos_r;
    over_nxt       = over_r;
    riff_nxt       = riff_r;
    wave_nxt       = wave_r;
    kind_nxt       = kind_r;
    chunk_end_nxt  = chunk_end_r;
    body_start_nxt = body_start_r;
    chunk_len_nxt  = chunk_len_r;
    pend_fmt_nxt   = pend_fmt_r;
    pend_ch_nxt    = pend_ch_r;
    pend_rate_nxt  = pend_rate_r;
    pend_bits_nxt  = pend_bits_r;
    fmt_code_nxt   = fmt_code_r;
    ch_num_nxt     = ch_num_r;
    rate_nxt       = rate_r;
    bits_nxt       = bits_r;
    data_begin_nxt = data_begin_r;
    data_bytes_nxt = data_bytes_r;
    fmt_err_nxt    = fmt_err_r;
    stopped_nxt    = stopped_r;
    fin            = 1'b0;
    fin_kind       = kind_r;
    fin_len        = chunk_len_r;
    fin_begin      = body_start_r[31:0];

    if (!over_r) begin
      if (pos_r == OFFSET_BITS'(RIFF_LAST)) begin
        riff_nxt = (hdr_len == ID_RIFF);
      end
      if (pos_r == OFFSET_BITS'(WAVE_LAST)) begin
        wave_nxt = (hdr_len == ID_WAVE);
      end
      if (!stopped_r) begin
        if (pos_w >= chunk_end_r) begin
          // chunk header, id and length complete on its eighth byte
          if (pos_w == chunk_end_r + CE_W'(HDR_LAST)) begin
            if (hdr_id == ID_FMT) begin
              kind_nxt = KIND_FMT;
            end else if (hdr_id == ID_DATA) begin
              kind_nxt = KIND_DATA;
            end else begin
              kind_nxt = KIND_OTHER;
            end
            chunk_len_nxt  = hdr_len;
            body_start_nxt = pos_w + CE_W'(1);
            chunk_end_nxt  = pos_w + CE_W'(1) + CE_W'(hdr_len);
            if (hdr_len == 32'd0) begin
              fin       = 1'b1;
              fin_kind  = kind_nxt;
              fin_len   = 32'd0;
              fin_begin = body_start_nxt[31:0];
            end
          end
        end else if (pos_w >= body_start_r) begin
          if (kind_r == KIND_FMT && body_off[CE_W-1:4] == '0) begin
            case (body_off[3:0])
              4'd0:    pend_fmt_nxt[7:0]    = byte_in;
              4'd1:    pend_fmt_nxt[15:8]   = byte_in;
              4'd2:    pend_ch_nxt[7:0]     = byte_in;
              4'd3:    pend_ch_nxt[15:8]    = byte_in;
              4'd4:    pend_rate_nxt[7:0]   = byte_in;
              4'd5:    pend_rate_nxt[15:8]  = byte_in;
              4'd6:    pend_rate_nxt[23:16] = byte_in;
              4'd7:    pend_rate_nxt[31:24] = byte_in;
              4'd14:   pend_bits_nxt[7:0]   = byte_in;
              4'd15:   pend_bits_nxt[15:8]  = byte_in;
              default: pend_fmt_nxt         = pend_fmt_r;
            endcase
          end
          if (pos_w == chunk_end_r - CE_W'(1)) begin
            fin = 1'b1;
          end
        end
      end

      if (fin) begin
        case (fin_kind)
          KIND_FMT: begin
            if (fin_len < 32'(MIN_FMT)) begin
              fmt_err_nxt = 1'b1;
              stopped_nxt = 1'b1;
            end else begin
              fmt_code_nxt = pend_fmt_nxt;
              ch_num_nxt   = pend_ch_nxt;
              rate_nxt     = pend_rate_nxt;
              bits_nxt     = pend_bits_nxt;
            end
          end
          KIND_DATA: begin
            data_begin_nxt = fin_begin;
            data_bytes_nxt = fin_len;
          end
          default: fmt_err_nxt = fmt_err_r;
        endcase
      end

      if (pos_r == '1) begin
        over_nxt = 1'b1;
      end
      pos_nxt = pos_r + OFFSET_BITS'(1);
    end
  end

  always_comb begin
    if (over_r) begin
      res.status = ST_TOO_LONG;
    end else if (pos_r < OFFSET_BITS'(MIN_FILE - 1)) begin
      res.status = ST_SHORT;
    end else if (!riff_nxt) begin
      res.status = ST_NO_RIFF;
    end else if (!wave_nxt) begin
      res.status = ST_NO_WAVE;
    end else if (fmt_err_nxt) begin
      res.status = ST_FMT_SMALL;
    end else if (data_bytes_nxt == 32'd0) begin
      res.status = ST_NO_DATA;
    end else if (fmt_code_nxt != 16'd1) begin
      res.status = ST_NOT_PCM;
    end else if (bits_nxt != 16'd16) begin
      res.status = ST_NOT_16BIT;
    end else if (ch_num_nxt != 16'd1 && ch_num_nxt != 16'd2) begin
      res.status = ST_BAD_CHANNELS;
    end else begin
      res.status = ST_OK;
    end
    res.channel_count = ch_num_nxt;
    res.sample_rate   = rate_nxt;
    res.data_start    = data_begin_nxt;
    res.sample_total  = data_bytes_nxt[31:1];
  end

  // the last byte of a file returns everything to the start state
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && last_in)) begin
      pos_r        <= '0;
      over_r       <= 1'b0;
      shift_r      <= '0;
      riff_r       <= 1'b0;
      wave_r       <= 1'b0;
      kind_r       <= KIND_OTHER;
      chunk_end_r  <= CE_W'(CHUNK_START);
      body_start_r <= CE_W'(CHUNK_START);
      chunk_len_r  <= '0;
      pend_fmt_r   <= '0;
      pend_ch_r    <= '0;
      pend_rate_r  <= '0;
      pend_bits_r  <= '0;
      fmt_code_r   <= '0;
      ch_num_r     <= '0;
      rate_r       <= '0;
      bits_r       <= '0;
      data_begin_r <= '0;
      data_bytes_r <= '0;
      fmt_err_r    <= 1'b0;
      stopped_r    <= 1'b0;
    end else if (step_en) begin
      pos_r        <= pos_nxt;
      over_r       <= over_nxt;
      shift_r      <= shift_nxt;
      riff_r       <= riff_nxt;
      wave_r       <= wave_nxt;
      kind_r       <= kind_nxt;
      chunk_end_r  <= chunk_end_nxt;
      body_start_r <= body_start_nxt;
      chunk_len_r  <= chunk_len_nxt;
      pend_fmt_r   <= pend_fmt_nxt;
      pend_ch_r    <= pend_ch_nxt;
      pend_rate_r  <= pend_rate_nxt;
      pend_bits_r  <= pend_bits_nxt;
      fmt_code_r   <= fmt_code_nxt;
      ch_num_r     <= ch_num_nxt;
      rate_r       <= rate_nxt;
      bits_r       <= bits_nxt;
      data_begin_r <= data_begin_nxt;
      data_bytes_r <= data_bytes_nxt;
      fmt_err_r    <= fmt_err_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

endmodule

// File: rtl/wavhp_chk.sv
module wavhp_chk import wavhp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_is_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_status,
  input logic [15:0] out_channel_count,
  input logic [31:0] out_sample_rate,
  input logic [31:0] out_data_start,
  input logic [30:0] out_sample_total
);

  // a fresh summary follows a taken last byte
  a_summary_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_is_last, 2))
    else $error("summary without a last byte");

  a_ok_channels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      (out_channel_count == 16'd1 || out_channel_count == 16'd2))
    else $error("ok summary with bad channel count");

  a_ok_samples: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_sample_total != 31'd0 ||
      out_data_start != 32'd0)
    else $error("ok summary without data chunk");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_channel_count) && $stable(out_sample_rate) &&
      $stable(out_data_start) && $stable(out_sample_total))
    else $error("stalled summary changed");

endmodule

bind wav_header_chunk_parser_unit wavhp_chk u_wavhp_chk (.*);
